// File: rtl/mmp_pkg.sv
// Shared types and constants for the min/max pyramid builder.
// No dependencies; every other file imports this package.
`default_nettype none

package mmp_pkg;

  // Field widths fixed by the transaction formats
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 5;
  localparam int INDEX_W  = 23;

  // Input transaction: one audio sample
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_sample;
  } item_t;

  // Output transaction: one completed pair
  typedef struct packed {
    logic        [LEVEL_W-1:0]  level;
    logic        [INDEX_W-1:0]  entry_index;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic                       last_of_run;
  } result_t;

  // Commands from the sequencer to the level store
  typedef struct packed {
    logic clear_all;  // new stream: drop pending halves and counters
    logic set_pend;   // park the running min/max as a first half
    logic take_pend;  // consume the first half and bump the level count
  } store_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mmp_minmax.sv
// Shared compare unit: merges a stored min/max pair with the running pair.
// Depends on mmp_pkg for the sample width.
`default_nettype none

module mmp_minmax (
  input  wire logic signed [mmp_pkg::SAMPLE_W-1:0] a_min,
  input  wire logic signed [mmp_pkg::SAMPLE_W-1:0] a_max,
  input  wire logic signed [mmp_pkg::SAMPLE_W-1:0] b_min,
  input  wire logic signed [mmp_pkg::SAMPLE_W-1:0] b_max,
  output logic signed [mmp_pkg::SAMPLE_W-1:0]      merged_min,
  output logic signed [mmp_pkg::SAMPLE_W-1:0]      merged_max
);
  import mmp_pkg::*;

  // Pick the smaller low bound and the larger high bound
  always_comb begin
    merged_min = (a_min < b_min) ? a_min : b_min;
    merged_max = (a_max > b_max) ? a_max : b_max;
  end

endmodule

`default_nettype wire

// File: rtl/mmp_store.sv
// Per-level state: pending flags, pending min/max halves and entry counters.
// Depends on mmp_pkg for widths and the store command struct.
`default_nettype none

module mmp_store #(
  parameter int MAX_LEVELS = 24,
  parameter int LVL_W      = 5
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mmp_pkg::store_ctrl_t                ctrl,
  input  wire logic [LVL_W-1:0]                    lvl,
  input  wire logic signed [mmp_pkg::SAMPLE_W-1:0] wr_min,
  input  wire logic signed [mmp_pkg::SAMPLE_W-1:0] wr_max,
  output logic [MAX_LEVELS-1:0]                    flags,
  output logic signed [mmp_pkg::SAMPLE_W-1:0]      rd_min,
  output logic signed [mmp_pkg::SAMPLE_W-1:0]      rd_max,
  output logic [mmp_pkg::INDEX_W-1:0]              rd_count
);
  import mmp_pkg::*;

  logic signed [SAMPLE_W-1:0] pend_min [MAX_LEVELS];
  logic signed [SAMPLE_W-1:0] pend_max [MAX_LEVELS];
  logic [INDEX_W-1:0]         count    [MAX_LEVELS];

  // Track which levels hold a first half
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_all) begin
      flags <= '0;
    end else if (ctrl.set_pend) begin
      flags[lvl] <= 1'b1;
    end else if (ctrl.take_pend) begin
      flags[lvl] <= 1'b0;
    end
  end

  // Hold the parked halves; valid only while the level's flag is set
  always_ff @(posedge clk) begin
    if (ctrl.set_pend) begin
      pend_min[lvl] <= wr_min;
      pend_max[lvl] <= wr_max;
    end
  end

  // Count emitted entries per level, wrapping at the index width
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_all) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        count[i] <= '0;
      end
    end else if (ctrl.take_pend) begin
      count[lvl] <= count[lvl] + INDEX_W'(1);
    end
  end

  assign rd_min   = pend_min[lvl];
  assign rd_max   = pend_max[lvl];
  assign rd_count = count[lvl];

endmodule

`default_nettype wire

// File: rtl/min_max_pyramid_builder.sv
// Top level of the streaming min/max pyramid builder: sequencer and output register.
// Depends on mmp_pkg, mmp_store and mmp_minmax.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------
//  item     | in        | item_valid / item_ready    | mmp_pkg::item_t
//  result   | out       | result_valid / result_ready| mmp_pkg::result_t
//
// A sample is accepted, then visits the levels in turn: each level holding a first half
// completes a pair and carries the merged pair up; the walk ends by parking at the first
// level without a first half, or by completing the top level.
// Unstalled, the sequencer walks levels one per cycle via the single compare unit.
// Reset (rst, synchronous) clears all pending halves and counters.
// A stalled result holds the walk on its level; item_ready stays low until done.
`default_nettype none

module min_max_pyramid_builder #(
  parameter int MAX_LEVELS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire mmp_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output mmp_pkg::result_t      result
);
  import mmp_pkg::*;

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                       state;
  logic [LVL_W-1:0]           lvl;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;

  store_ctrl_t                ctrl;
  logic [MAX_LEVELS-1:0]      flags;
  logic signed [SAMPLE_W-1:0] pend_min;
  logic signed [SAMPLE_W-1:0] pend_max;
  logic [INDEX_W-1:0]         pend_count;
  logic signed [SAMPLE_W-1:0] merged_min;
  logic signed [SAMPLE_W-1:0] merged_max;

  logic             accept;
  logic             out_free;
  logic             cur_pend;
  logic             is_top;
  logic [LVL_W-1:0] lvl_up;
  logic             next_pend;
  logic             emit;
  logic             park;

  mmp_store #(
    .MAX_LEVELS (MAX_LEVELS),
    .LVL_W      (LVL_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .lvl      (lvl),
    .wr_min   (run_min),
    .wr_max   (run_max),
    .flags    (flags),
    .rd_min   (pend_min),
    .rd_max   (pend_max),
    .rd_count (pend_count)
  );

  mmp_minmax u_minmax (
    .a_min      (pend_min),
    .a_max      (pend_max),
    .b_min      (run_min),
    .b_max      (run_max),
    .merged_min (merged_min),
    .merged_max (merged_max)
  );

  // Decide the action for the current level
  always_comb begin
    item_ready = (state == ST_IDLE);
    accept     = item_valid && item_ready;
    out_free   = !result_valid || result_ready;
    cur_pend   = flags[lvl];
    is_top     = (lvl == LVL_W'(MAX_LEVELS - 1));
    lvl_up     = lvl + LVL_W'(1);
    next_pend  = is_top ? 1'b0 : flags[lvl_up];
    park       = (state == ST_RUN) && !cur_pend;
    emit       = (state == ST_RUN) && cur_pend && out_free;

    ctrl.clear_all = accept && item.first_sample;
    ctrl.set_pend  = park;
    ctrl.take_pend = emit;
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) state <= ST_RUN;
        end
        ST_RUN: begin
          if (park || (emit && is_top)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Load the sample, then carry each merged pair one level up
  always_ff @(posedge clk) begin
    if (accept) begin
      lvl     <= '0;
      run_min <= item.sample;
      run_max <= item.sample;
    end else if (emit) begin
      lvl     <= lvl_up;
      run_min <= merged_min;
      run_max <= merged_max;
    end
  end

  // Hold the result transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.level       <= LEVEL_W'(lvl);
      result.entry_index <= pend_count;
      result.min_value   <= merged_min;
      result.max_value   <= merged_max;
      result.last_of_run <= !next_pend;
    end
  end

endmodule

`default_nettype wire
